### sv/rft_pkg.sv
// Package for the reduced-fraction totient block.
// Holds the shared constants and the divider request type; no dependencies.
package rft_pkg;

  localparam int unsigned PrimeLimitDef = 100001;
  localparam int unsigned ValueBitsDef  = 33;

  // Divider operation tag; the sequencer and the divider do not use it.
  typedef enum logic [1:0] {
    DivGcd   = 2'd0,
    DivQuot  = 2'd1,
    DivTrial = 2'd2,
    DivAns   = 2'd3
  } div_op_e;

endpackage

### sv/reduced_fraction_totient.sv
// Reduced-fraction totient: phi(n / gcd(m, n)) by trial division.
// Top level; instantiates rft_prime_rom and rft_divider, uses rft_pkg.
//
// Usage: offer numerator_i/denominator_i with in_valid_i; the transaction
// is taken when in_ready_o is high. One result per input appears on
// totient_value_o with out_valid_o and is held until out_ready_i.
// After reset the block builds its prime ROM: a clearing pass over the sieve
// flags, then a test of each candidate and a strike-out of each multiple of
// each prime found; in_ready_o stays low until the ROM is complete.
// Work per item: the gcd takes one division per Euclid step (up to ~50
// steps), then each table prime with p*p <= cofactor costs one division
// plus a ROM read; each factor removed costs one more division and each
// distinct prime factor one more for the update. The single shared
// divider carries all of these divisions in turn.
// Only one item is in work at a time: in_ready_o falls on acceptance and
// rises again once the result has been taken. A stalled receiver holds
// the result register and the block.
// A zero denominator answers zero.
module reduced_fraction_totient #(
  parameter int unsigned PrimeLimit = rft_pkg::PrimeLimitDef,
  parameter int unsigned ValueBits  = rft_pkg::ValueBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ValueBits-1:0] numerator_i,
  input  logic [ValueBits-1:0] denominator_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [ValueBits-1:0] totient_value_o
);
  import rft_pkg::*;

  localparam int unsigned PrimeBits = $clog2(PrimeLimit + 1);
  localparam int unsigned Depth     = PrimeLimit / 2 + 2;
  localparam int unsigned AddrBits  = $clog2(Depth);

  typedef enum logic [3:0] {
    StIdle, StGcdDiv, StGcdWait, StQuotWait, StFetch, StRomWait, StCheck,
    StTrialWait, StAnsWait, StLastWait, StOut
  } st_state_e;

  st_state_e            state_q, state_d;
  logic [ValueBits-1:0] a_q, a_d;     // gcd left operand, then cofactor n
  logic [ValueBits-1:0] b_q, b_d;     // gcd right operand
  logic [ValueBits-1:0] ans_q, ans_d;
  logic [ValueBits-1:0] den_q, den_d;
  logic [AddrBits:0]    k_q, k_d;
  logic                 hit_q, hit_d;
  logic                 out_valid_q, out_valid_d;
  logic [ValueBits-1:0] res_q, res_d;

  logic                 div_start;
  logic [ValueBits-1:0] div_a, div_b;
  logic                 div_done;
  logic [ValueBits-1:0] div_q, div_r;

  logic [PrimeBits-1:0] prime;
  logic [AddrBits:0]    prime_cnt;
  logic                 rom_built;
  logic [ValueBits-1:0] p_ext;
  logic [2*ValueBits-1:0] p_sq;

  rft_prime_rom #(
    .PrimeLimit (PrimeLimit),
    .PrimeBits  (PrimeBits),
    .Depth      (Depth),
    .AddrBits   (AddrBits)
  ) u_rom (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (k_q[AddrBits-1:0]),
    .rd_data_o (prime),
    .count_o   (prime_cnt),
    .built_o   (rom_built)
  );

  rft_divider #(
    .ValueBits (ValueBits)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // Widen the table prime; a limit wider than the value would not fit.
  if (PrimeBits >= ValueBits) begin : g_pw
    assign p_ext = prime[ValueBits-1:0];
  end else begin : g_pn
    assign p_ext = {{(ValueBits-PrimeBits){1'b0}}, prime};
  end
  assign p_sq = {{ValueBits{1'b0}}, p_ext} * {{ValueBits{1'b0}}, p_ext};

  assign in_ready_o = (state_q == StIdle) && rom_built;

  always_comb begin
    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    ans_d       = ans_q;
    den_d       = den_q;
    k_d         = k_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    res_d       = res_q;
    div_start   = 1'b0;
    div_a       = a_q;
    div_b       = b_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          a_d   = numerator_i;
          b_d   = denominator_i;
          den_d = denominator_i;
          if (denominator_i == '0) begin
            res_d       = '0;
            out_valid_d = 1'b1;
            state_d     = StOut;
          end else begin
            state_d = StGcdDiv;
          end
        end
      end
      StGcdDiv: begin
        // Euclid: stop when b is zero, a holds the gcd.
        if (b_q == '0) begin
          div_start = 1'b1;
          div_a     = den_q;
          div_b     = a_q;
          state_d   = StQuotWait;
        end else begin
          div_start = 1'b1;
          state_d   = StGcdWait;
        end
      end
      StGcdWait: begin
        if (div_done) begin
          a_d     = b_q;
          b_d     = div_r;
          state_d = StGcdDiv;
        end
      end
      StQuotWait: begin
        if (div_done) begin
          a_d     = div_q;
          ans_d   = div_q;
          k_d     = '0;
          state_d = StFetch;
        end
      end
      StFetch: begin
        if (k_q == prime_cnt) begin
          state_d = StCheck;
        end else begin
          hit_d   = 1'b0;
          state_d = StRomWait;
        end
      end
      StRomWait: state_d = StCheck;
      StCheck: begin
        if (k_q == prime_cnt || p_sq > {{ValueBits{1'b0}}, a_q}) begin
          if (a_q > ValueBits'(1)) begin
            div_start = 1'b1;
            div_a     = ans_q;
            div_b     = a_q;
            state_d   = StLastWait;
          end else begin
            res_d       = ans_q;
            out_valid_d = 1'b1;
            state_d     = StOut;
          end
        end else begin
          div_start = 1'b1;
          div_b     = p_ext;
          state_d   = StTrialWait;
        end
      end
      StTrialWait: begin
        if (div_done) begin
          if (div_r == '0) begin
            // Drop the factor and try the same prime again.
            a_d       = div_q;
            hit_d     = 1'b1;
            div_start = 1'b1;
            div_a     = div_q;
            div_b     = p_ext;
          end else if (hit_q) begin
            div_start = 1'b1;
            div_a     = ans_q;
            div_b     = p_ext;
            state_d   = StAnsWait;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = StFetch;
          end
        end
      end
      StAnsWait: begin
        if (div_done) begin
          ans_d   = ans_q - div_q;
          k_d     = k_q + 1'b1;
          state_d = StFetch;
        end
      end
      StLastWait: begin
        if (div_done) begin
          res_d       = ans_q - div_q;
          out_valid_d = 1'b1;
          state_d     = StOut;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      hit_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      hit_q       <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    ans_q <= ans_d;
    den_q <= den_d;
    res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign totient_value_o = res_q;

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == StOut))
    else $error("result valid outside output state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input ready while result pending");
  a_nonzero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && den_q != '0) |-> (totient_value_o != '0))
    else $error("zero totient for nonzero denominator");
`endif

endmodule

### sv/rft_prime_rom.sv
// Prime ROM for the reduced-fraction totient block.
// Builds the ascending prime list at reset with a sieve over a flag memory; uses rft_pkg.
module rft_prime_rom #(
  parameter int unsigned PrimeLimit = rft_pkg::PrimeLimitDef,
  parameter int unsigned PrimeBits  = $clog2(PrimeLimit + 1),
  parameter int unsigned Depth      = PrimeLimit / 2 + 2,
  parameter int unsigned AddrBits   = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [AddrBits-1:0]  rd_addr_i,
  output logic [PrimeBits-1:0] rd_data_o,
  output logic [AddrBits:0]    count_o,
  output logic                 built_o
);
  import rft_pkg::*;

  localparam int unsigned FlagBits = $clog2(PrimeLimit + 2);
  localparam int unsigned StepBits = FlagBits + 1;

  // Clear the flags, then take each candidate through the scan and test
  // states; an unflagged candidate is prime, store it and strike out its
  // multiples from its square upwards, one a cycle.
  typedef enum logic [2:0] {
    SvClear, SvScan, SvTest, SvMark, SvDone
  } sv_state_e;

  logic [PrimeBits-1:0] mem [Depth];
  logic [PrimeBits-1:0] mem_rd_q;
  logic                 flag_mem [PrimeLimit+1];
  logic                 flag_rd_q;
  logic [PrimeBits-1:0] flag_addr;
  logic                 flag_we;
  logic                 flag_wd;

  sv_state_e             state_q, state_d;
  logic [FlagBits-1:0]   cand_q, cand_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic [AddrBits:0]     cnt_q, cnt_d;
  logic                  wr_en;
  logic [2*FlagBits-1:0] sq;
  logic [StepBits-1:0]   next_step;

  assign sq        = {{FlagBits{1'b0}}, cand_q} * {{FlagBits{1'b0}}, cand_q};
  assign next_step = step_q + {1'b0, cand_q};

  always_comb begin
    state_d   = state_q;
    cand_d    = cand_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    wr_en     = 1'b0;
    flag_addr = cand_q[PrimeBits-1:0];
    flag_we   = 1'b0;
    flag_wd   = 1'b0;
    unique case (state_q)
      SvClear: begin
        flag_we = 1'b1;
        if (cand_q == FlagBits'(PrimeLimit)) begin
          cand_d  = FlagBits'(2);
          state_d = SvScan;
        end else begin
          cand_d = cand_q + 1'b1;
        end
      end
      SvScan: begin
        if (cand_q > FlagBits'(PrimeLimit)) begin
          state_d = SvDone;
        end else begin
          state_d = SvTest;
        end
      end
      SvTest: begin
        if (!flag_rd_q) begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
          if (sq <= (2*FlagBits)'(PrimeLimit)) begin
            step_d  = sq[StepBits-1:0];
            state_d = SvMark;
          end else begin
            cand_d  = cand_q + 1'b1;
            state_d = SvScan;
          end
        end else begin
          cand_d  = cand_q + 1'b1;
          state_d = SvScan;
        end
      end
      SvMark: begin
        flag_addr = step_q[PrimeBits-1:0];
        flag_we   = 1'b1;
        flag_wd   = 1'b1;
        if (next_step > StepBits'(PrimeLimit)) begin
          cand_d  = cand_q + 1'b1;
          state_d = SvScan;
        end else begin
          step_d = next_step;
        end
      end
      SvDone: state_d = SvDone;
      default: state_d = SvDone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SvClear;
      cand_q  <= '0;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cand_q  <= cand_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[flag_addr] <= flag_wd;
    end
    flag_rd_q <= flag_mem[flag_addr];
    if (wr_en) begin
      mem[cnt_q[AddrBits-1:0]] <= cand_q[PrimeBits-1:0];
    end
    mem_rd_q <= mem[rd_addr_i];
  end

  assign rd_data_o = mem_rd_q;
  assign count_o   = cnt_q;
  assign built_o   = (state_q == SvDone);

endmodule

### sv/rft_divider.sv
// Shared restoring divider for the reduced-fraction totient block.
// One quotient bit per cycle; uses rft_pkg.
module rft_divider #(
  parameter int unsigned ValueBits = rft_pkg::ValueBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ValueBits-1:0] dividend_i,
  input  logic [ValueBits-1:0] divisor_i,
  output logic                 done_o,
  output logic [ValueBits-1:0] quot_o,
  output logic [ValueBits-1:0] rem_o
);
  import rft_pkg::*;

  localparam int unsigned CntBits = $clog2(ValueBits + 1);

  logic [ValueBits-1:0] quot_q, quot_d;
  logic [ValueBits:0]   rem_q, rem_d;
  logic [ValueBits-1:0] dvs_q, dvs_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [ValueBits:0]   shifted;

  assign shifted = {rem_q[ValueBits-1:0], quot_q[ValueBits-1]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntBits'(ValueBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Shift in one dividend bit, subtract where it fits.
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d  = shifted - {1'b0, dvs_q};
        quot_d = {quot_q[ValueBits-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[ValueBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[ValueBits-1:0];

endmodule

### dv/tb_reduced_fraction_totient.sv
// Self-checking testbench for reduced_fraction_totient: phi(n / gcd(m, n)).
// Depends on the RTL top level and its package; results are checked in order on
// the result channel against a typed-in answer or a local trial-division model.
`timescale 1ns / 1ps

module tb_reduced_fraction_totient;

  localparam int unsigned VW        = 33;
  localparam longint      IdleLimit = 64'd40_000_000;
  localparam int unsigned NumRows   = 14;
  localparam int unsigned PhaseLen  = 25;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [VW-1:0] numerator_i = '0;
  logic [VW-1:0] denominator_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [VW-1:0] totient_value_o;

  // Held alongside the payload: a typed-in answer overrides the model.
  logic          fixed_known = 1'b0;
  logic [VW-1:0] fixed_answer = '0;

  logic [VW-1:0] totient_due[$];
  int unsigned   fail_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  longint        quiet_cycles = 0;

  typedef struct {
    logic [VW-1:0] num;
    logic [VW-1:0] den;
    logic          known;
    logic [VW-1:0] answer;
  } stim_row_t;

  stim_row_t directed_rows[NumRows] = '{
    '{33'd0,           33'd1,            1'b1, 33'd1},           // zero numerator
    '{33'd0,           33'h1_FFFF_FFFF,  1'b1, 33'd1},
    '{33'h1_FFFF_FFFF, 33'h1_FFFF_FFFF,  1'b1, 33'd1},           // quotient of one
    '{33'd1,           33'd1,            1'b1, 33'd1},
    '{33'h1_FFFF_FFFF, 33'd0,            1'b1, 33'd0},           // zero denominator
    '{33'd0,           33'd0,            1'b1, 33'd0},
    '{33'd1,           33'd4294967291,   1'b1, 33'd4294967290},  // large prime
    '{33'd1,           33'h1_0000_0000,  1'b1, 33'h0_8000_0000}, // power of two
    '{33'd6,           33'd12,           1'b1, 33'd1},
    '{33'd3,           33'd9,            1'b1, 33'd2},
    '{33'd1,           33'h1_FFFF_FFFF,  1'b0, 33'd0},
    '{33'd7,           33'd8633,         1'b0, 33'd0},
    '{33'h0_AAAA_AAAA, 33'h1_5555_5554,  1'b0, 33'd0},
    '{33'd1,           33'd2,            1'b1, 33'd1}
  };

  reduced_fraction_totient i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .numerator_i,
    .denominator_i,
    .out_valid_o,
    .out_ready_i,
    .totient_value_o
  );

  always #5 clk_i = ~clk_i;

  // Reduce n by gcd(m, n), then take the totient by trial division.
  function automatic logic [VW-1:0] reduced_totient(logic [VW-1:0] m, logic [VW-1:0] n);
    logic [63:0] a, b, r, q, ans, p;
    if (n == '0) return '0;
    a = 64'(m);
    b = 64'(n);
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    q = 64'(n) / a;
    ans = q;
    for (p = 2; p * p <= q; p++) begin
      if (q % p == 0) begin
        while (q % p == 0) q = q / p;
        ans -= ans / p;
      end
    end
    if (q > 1) ans -= ans / q;
    return ans[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] rand_value();
    return {1'($urandom()), 32'($urandom())};
  endfunction

  // Product of small primes: big values that still factor quickly.
  function automatic logic [VW-1:0] smooth_value();
    logic [63:0] acc;
    logic [63:0] p;
    int unsigned steps;
    int unsigned primes[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 97};
    acc = 1;
    steps = $urandom_range(40, 1);
    repeat (steps) begin
      p = primes[$urandom_range(11)];
      if (acc * p < 64'h2_0000_0000) acc = acc * p;
    end
    return acc[VW-1:0];
  endfunction

  // Offer one transaction at the falling edge and hold it until taken.
  task automatic offer(logic [VW-1:0] m, logic [VW-1:0] n, logic known, logic [VW-1:0] ans);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    numerator_i   = m;
    denominator_i = n;
    fixed_known   = known;
    fixed_answer  = ans;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic offer_random();
    logic [VW-1:0] m, n;
    int unsigned kind;
    kind = $urandom_range(9);
    m = rand_value();
    case (kind)
      0, 1, 2, 3: begin
        n = smooth_value();
      end
      4, 5: begin
        n = VW'($urandom_range(65535, 1));
      end
      6: begin
        // numerator a multiple of the denominator: quotient of one
        n = smooth_value() | VW'(1) << 32;
        m = n;
      end
      7: begin
        n = VW'($urandom_range(255, 1)) << $urandom_range(25, 8);
      end
      default: begin
        // fully random denominators are slow; keep them rare
        n = ($urandom_range(5) == 0) ? rand_value() : smooth_value();
        if (n == '0) n = 1;
      end
    endcase
    offer(m, n, 1'b0, '0);
  endtask

  // Receiver stalls, redrawn every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Log accepted inputs, check accepted results, run the watchdog.
  always @(posedge clk_i) begin
    logic [VW-1:0] due;
    if (rst_ni && in_valid_i && in_ready_o) begin
      totient_due.insert(totient_due.size(),
                         fixed_known ? fixed_answer
                                     : reduced_totient(numerator_i, denominator_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (totient_due.size() == 0) begin
        $error("unexpected transaction: totient_value %0d", totient_value_o);
        fail_count++;
      end else begin
        due = totient_due.pop_front();
        if (totient_value_o !== due) begin
          $error("totient_value mismatch: expected %0d, actual %0d", due, totient_value_o);
          fail_count++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain();
    while (totient_due.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned idle_by_phase[4]  = '{0, 88, 0, 35};
    int unsigned stall_by_phase[4] = '{0, 0, 88, 35};
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table first, no idling.
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].num, directed_rows[i].den,
            directed_rows[i].known, directed_rows[i].answer);
    end

    // Random phases; hold the sender until the block is empty between them.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      send_idle_pct  = idle_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      repeat (PhaseLen) offer_random();
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
